// ===== hw/rtl/mtg_pkg.sv =====
// Package for the Mersenne-Twister-style generator.
// Holds sizes, generator constants, the seed datapath control struct and
// the tempering and twist-mix functions. No dependencies.
package mtg_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned TAP_OFFSET  = 397;
  localparam int unsigned SPAN_DIFF   = STATE_WORDS - TAP_OFFSET;
  localparam int unsigned IDX_W       = $clog2(STATE_WORDS + 1);
  localparam int unsigned WORD_W      = 64;

  localparam logic [31:0] LCG_MUL     = 32'd2147001325;
  localparam logic [31:0] LCG_ADD     = 32'd715136305;
  localparam logic [31:0] LCG_XOR     = 32'h31415926;
  localparam logic [31:0] TWIST_XOR   = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc60000;

  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_GEN  = 1'b1;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic step;
  } seed_ctrl_t;

  function automatic logic [31:0] mix_pair(input logic hi_bit, input logic [30:0] lo_bits);
    logic [31:0] t;
    t = {hi_bit, lo_bits};
    return (t >> 1) ^ (t[0] ? TWIST_XOR : 32'h0);
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & {32'h0, TEMPER_B});
    y = y ^ ((y << 15) & {32'h0, TEMPER_C});
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mersenne_twister_generator.sv =====
// Generate: the word is read from memory, then tempered into the output register once
// the output is free. A generate that finds all words used first runs the twist pass.
// Seed: each word passes the multiply-low, multiply-high, sum and write steps in turn.
// One item at a time: the next item is taken only after the current one is finished.
// Reset clears control state only; the word memory is undefined until
// the first seed, and a generate before any seed seeds with zero first.
module mersenne_twister_generator import mtg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [63:0]       s_axis_tdata_i,   // [63:0] seed_value
  input  logic              s_axis_tuser_i,   // [0] func
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [63:0]       m_axis_tdata_o    // [63:0] random_value
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_FMLO   = 11'b000_0000_0010,
    S_FMHI   = 11'b000_0000_0100,
    S_FSUM   = 11'b000_0000_1000,
    S_FWR    = 11'b000_0001_0000,
    S_TPRIME = 11'b000_0010_0000,
    S_TA     = 11'b000_0100_0000,
    S_TB     = 11'b000_1000_0000,
    S_TLAST  = 11'b001_0000_0000,
    S_GRD    = 11'b010_0000_0000,
    S_GOUT   = 11'b100_0000_0000
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] USED_UP  = IDX_W'(STATE_WORDS);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               unseeded_q, unseeded_d;
  logic               pend_q, pend_d;
  logic               hi_q, hi_d;
  logic [31:0]        nxt_q, nxt_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_data_q, out_data_d;

  logic               in_acc;
  logic               out_free;
  seed_ctrl_t         seed_ctrl;
  logic [WORD_W-1:0]  seed_word;
  logic [WORD_W-1:0]  seed_load;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [WORD_W-1:0]  wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic [WORD_W-1:0]  rdata;

  logic [IDX_W-1:0]   k_next;
  logic [IDX_W-1:0]   k_tap;
  logic [WORD_W-1:0]  twisted;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign k_next  = (k_q == LAST_IDX) ? '0 : k_q + IDX_W'(1);
  assign k_tap   = (k_q < IDX_W'(SPAN_DIFF)) ? k_q + IDX_W'(TAP_OFFSET)
                                             : k_q - IDX_W'(SPAN_DIFF);
  assign twisted = rdata ^ {32'h0, mix_pair(hi_q, nxt_q[30:0])};

  assign seed_load = (s_axis_tuser_i == FUNC_SEED) ? s_axis_tdata_i : '0;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    pos_d       = pos_q;
    unseeded_d  = unseeded_q;
    pend_d      = pend_q;
    hi_d        = hi_q;
    nxt_d       = nxt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    seed_ctrl   = '0;
    we          = 1'b0;
    waddr       = k_q;
    wdata       = twisted;
    re          = 1'b0;
    raddr       = pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == FUNC_SEED || unseeded_q) begin
            seed_ctrl.load = 1'b1;
            we             = 1'b1;
            waddr          = '0;
            wdata          = seed_load;
            k_d            = IDX_W'(1);
            pend_d         = (s_axis_tuser_i == FUNC_GEN);
            state_d        = S_FMLO;
          end else if (pos_q >= USED_UP) begin
            state_d = S_TPRIME;
          end else begin
            re      = 1'b1;
            raddr   = pos_q;
            state_d = S_GOUT;
          end
        end
      end
      S_FMLO: begin
        seed_ctrl.mul_lo = 1'b1;
        state_d          = S_FMHI;
      end
      S_FMHI: begin
        seed_ctrl.mul_hi = 1'b1;
        state_d          = S_FSUM;
      end
      S_FSUM: begin
        seed_ctrl.sum = 1'b1;
        state_d       = S_FWR;
      end
      S_FWR: begin
        seed_ctrl.step = 1'b1;
        we             = 1'b1;
        waddr          = k_q;
        wdata          = seed_word;
        if (k_q == LAST_IDX) begin
          pos_d      = USED_UP;
          unseeded_d = 1'b0;
          state_d    = pend_q ? S_TPRIME : S_IDLE;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_FMLO;
        end
      end
      S_TPRIME: begin
        re      = 1'b1;
        raddr   = '0;
        k_d     = '0;
        state_d = S_TA;
      end
      S_TA: begin
        re    = 1'b1;
        raddr = k_next;
        if (k_q == '0) begin
          hi_d = rdata[31];
        end else begin
          we    = 1'b1;
          waddr = k_q - IDX_W'(1);
          wdata = twisted;
          hi_d  = nxt_q[31];
        end
        state_d = S_TB;
      end
      S_TB: begin
        re    = 1'b1;
        raddr = k_tap;
        nxt_d = rdata[31:0];
        if (k_q == LAST_IDX) begin
          state_d = S_TLAST;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_TA;
        end
      end
      S_TLAST: begin
        we      = 1'b1;
        waddr   = LAST_IDX;
        wdata   = twisted;
        pos_d   = '0;
        pend_d  = 1'b0;
        state_d = S_GRD;
      end
      S_GRD: begin
        re      = 1'b1;
        raddr   = pos_q;
        state_d = S_GOUT;
      end
      S_GOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = temper(rdata);
          pos_d       = pos_q + IDX_W'(1);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      pos_q       <= USED_UP;
      unseeded_q  <= 1'b1;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      unseeded_q  <= unseeded_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    nxt_q      <= nxt_d;
    out_data_q <= out_data_d;
  end

  mtg_seed_dp u_seed_dp (
    .clk_i  (clk_i),
    .ctrl_i (seed_ctrl),
    .seed_i (seed_load),
    .word_o (seed_word)
  );

  mtg_ram #(
    .DEPTH (STATE_WORDS),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== hw/rtl/mtg_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No dependencies.
module mtg_ram #(
  parameter int unsigned DEPTH = 624,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mtg_seed_dp.sv =====
// Seed fill datapath: LCG step and shuffle per word in low-multiply, high-multiply,
// sum and step phases, sharing one 32x32 multiplier. Depends on mtg_pkg.
module mtg_seed_dp import mtg_pkg::*; (
  input  logic              clk_i,
  input  seed_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] seed_i,
  output logic [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] plo_q;
  logic [31:0]       phi_q;
  logic [WORD_W-1:0] v_q;
  logic [31:0]       mul_a;
  logic [63:0]       prod;
  logic [WORD_W-1:0] w;

  assign mul_a = ctrl_i.mul_hi ? x_q[63:32] : x_q[31:0];
  assign prod  = {32'h0, mul_a} * {32'h0, LCG_MUL};
  assign w     = {32'h0, LCG_XOR} ^ ((v_q >> 16) + (v_q << 16));

  always_comb begin
    x_d = x_q;
    if (ctrl_i.load) begin
      x_d = seed_i;
    end else if (ctrl_i.step) begin
      x_d = w;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (ctrl_i.mul_lo) begin
      plo_q <= prod;
    end
    if (ctrl_i.mul_hi) begin
      phi_q <= prod[31:0];
    end
    if (ctrl_i.sum) begin
      v_q <= plo_q + {phi_q, 32'h0} + {32'h0, LCG_ADD};
    end
  end

  assign word_o = w;

endmodule

// ===== hw/rtl/mtg_checker.sv =====
// Port-level checks for the generator, attached to the top level by bind.
// Depends on mersenne_twister_generator port names only.
module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("second item taken in the cycle after an accept");

  a_seed_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser_i && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("seed item produced a result");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
